@@ rtl/gcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// gcpa_pkg
// shared types, constants and register codes of the gaussian class
// probability block
// ----------------------------------------------------------------------------
package gcpa_pkg;

  localparam int MAX_CLASSES_DEF = 6;
  localparam int CLS_W           = 3;
  localparam int DENS_W          = 16;
  localparam int SUM_W           = 19;
  localparam int PROB_W          = 16;
  localparam int SD_W            = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // argument a in Q.16 clamps at 40.0
  localparam int ARG_W           = 22;
  localparam logic [ARG_W-1:0] ARG_LIMIT = 22'd2621440;
  localparam int E_W             = 33;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] EXP_LIN   = 16'd43060;
  localparam logic [13:0] EXP_QUAD  = 14'd10292;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT = 3'd0,
    REG_NOISE_SD    = 3'd1,
    REG_LEVEL_0     = 3'd2,
    REG_LEVEL_1     = 3'd3,
    REG_LEVEL_2     = 3'd4,
    REG_LEVEL_3     = 3'd5,
    REG_LEVEL_4     = 3'd6,
    REG_LEVEL_5     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DENS_W-1:0] density;
    logic [SUM_W-1:0]         prob_sum;
  } in_item_t;

  typedef struct packed {
    logic [CLS_W-1:0]         class_index;
    logic [PROB_W-1:0]        probability;
    logic signed [DENS_W-1:0] restored_level;
    logic                     is_last;
  } out_item_t;

  // per-class job tags carried beside the arithmetic
  typedef struct packed {
    logic [CLS_W-1:0] idx;
    logic             last;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic [CLS_W-1:0] idx;
    logic             last;
  } tag_t;

endpackage

@@ rtl/gcpa_div.sv @@
// ----------------------------------------------------------------------------
// gcpa_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module gcpa_div #(
  parameter int NW = 33,
  parameter int DW = 19,
  parameter int QW = 16,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          v   [QW+1];
  logic [W-1:0]  rem [QW+1];
  logic [DW-1:0] d   [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [SW-1:0] s   [QW+1];
  logic          ovf [QW+1];

  // entry stage: quotient too large for QW bits saturates
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num);
      d[0]   <= den;
      q[0]   <= '0;
      s[0]   <= side;
      ovf[0] <= W'(num) >= (W'(den) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [W-1:0]  shifted;
    logic          ge;
    logic [QW-1:0] q_next;

    always_comb begin
      shifted  = W'(d[k]) << B;
      ge       = rem[k] >= shifted;
      q_next   = q[k];
      q_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (en) v[k+1] <= v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - shifted : rem[k];
        d[k+1]   <= d[k];
        q[k+1]   <= q_next;
        s[k+1]   <= s[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = ovf[QW] ? '1 : q[QW];
  assign out_side  = s[QW];

endmodule

@@ rtl/gcpa_exp.sv @@
// ----------------------------------------------------------------------------
// gcpa_exp
// exp(-a) in Q1.32 from a in Q.16: base-2 split and quadratic fraction
// ----------------------------------------------------------------------------
module gcpa_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gcpa_pkg::ARG_W-1:0]  arg,
  input  gcpa_pkg::job_t              in_job,
  output logic                        out_valid,
  output logic [gcpa_pkg::E_W-1:0]    e,
  output gcpa_pkg::job_t              out_job
);

  logic                v1, v2, v3, v4;
  gcpa_pkg::job_t      j1, j2, j3;
  logic [5:0]          n1, n2, n3;
  logic [15:0]         f1;
  logic [31:0]         ff2, lin2, lin3;
  logic [29:0]         quad3;

  logic [gcpa_pkg::ARG_W-1:0] arg_c;
  logic [37:0]                t_prod;
  logic [45:0]                q_prod;
  logic [33:0]                m;

  always_comb begin
    arg_c  = (arg > gcpa_pkg::ARG_LIMIT) ? gcpa_pkg::ARG_LIMIT : arg;
    t_prod = 38'(arg_c) * 38'(gcpa_pkg::LOG2E_Q16);
    q_prod = 46'(gcpa_pkg::EXP_QUAD) * 46'(ff2);
    m      = 34'h1_0000_0000 - 34'(lin3) + 34'(quad3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // integer part n and fraction f of a*log2(e)
      n1   <= t_prod[37:32];
      f1   <= t_prod[31:16];
      j1   <= in_job;
      ff2  <= 32'(f1) * 32'(f1);
      lin2 <= 32'(gcpa_pkg::EXP_LIN) * 32'(f1);
      n2   <= n1;
      j2   <= j1;
      quad3 <= q_prod[45:16];
      lin3  <= lin2;
      n3    <= n2;
      j3    <= j2;
      e       <= gcpa_pkg::E_W'(m >> n3);
      out_job <= j3;
    end
  end

  assign out_valid = v4;

endmodule

@@ rtl/gcpa_issue.sv @@
// ----------------------------------------------------------------------------
// gcpa_issue
// takes a pixel beat, issues one class job per enabled cycle, squares offsets
// ----------------------------------------------------------------------------
module gcpa_issue #(
  parameter int MAX_CLASSES = gcpa_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gcpa_pkg::in_item_t                 in_data,
  input  logic [gcpa_pkg::CLS_W-1:0]         class_count,
  input  logic signed [gcpa_pkg::DENS_W-1:0] levels [MAX_CLASSES],
  output logic                               job_valid,
  output logic [31:0]                        d2,
  output gcpa_pkg::job_t                     job
);

  localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic                               busy;
  logic [gcpa_pkg::CLS_W-1:0]         cnt;
  logic [gcpa_pkg::CLS_W-1:0]         last_idx;
  logic signed [gcpa_pkg::DENS_W-1:0] dens;
  logic [gcpa_pkg::SUM_W-1:0]         sum;

  logic [gcpa_pkg::CLS_W-1:0] count_eff;
  logic                       issue_last;
  logic                       accept;

  logic                    va;
  gcpa_pkg::job_t          ja;
  logic signed [16:0]      diff_a;
  logic signed [33:0]      sq;

  always_comb begin
    if (class_count == '0) count_eff = gcpa_pkg::CLS_W'(1);
    else if (class_count > gcpa_pkg::CLS_W'(MAX_CLASSES))
      count_eff = gcpa_pkg::CLS_W'(MAX_CLASSES);
    else count_eff = class_count;
    issue_last = busy && en && (cnt == last_idx);
    in_stall   = busy && !issue_last;
    accept     = in_valid && !in_stall;
    sq         = diff_a * diff_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue_last) begin
      busy <= 1'b0;
    end else if (busy && en) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dens     <= in_data.density;
      sum      <= in_data.prob_sum;
      last_idx <= count_eff - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      job_valid <= 1'b0;
    end else if (en) begin
      va        <= busy;
      job_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_a  <= 17'(levels[cnt[IW-1:0]]) - 17'(dens);
      ja.idx  <= cnt;
      ja.last <= cnt == last_idx;
      ja.sum  <= sum;
      d2      <= sq[31:0];
      job     <= ja;
    end
  end

endmodule

@@ rtl/gaussian_class_probability_assign.sv @@
// ----------------------------------------------------------------------------
// gaussian_class_probability_assign
// per-pixel gaussian class probabilities and most likely class level
// ----------------------------------------------------------------------------
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | in_data: density, prob_sum
//   out     | out_valid/out_stall| out_data: class_index, probability,
//           |                    |           restored_level, is_last
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one class result per cycle unless out_stall holds a result back; a pixel
// holds off the next pixel until the issue counter has fed its class_count
// classes (1..6), one class per enabled cycle; a pixel beat passes the issue
// stage, argument divider, exponential, probability divider and output register
// rst is synchronous; it clears valid bits and loads register defaults
// out_stall on a valid result freezes the pipeline; nothing dropped or repeated
// ----------------------------------------------------------------------------
module gaussian_class_probability_assign #(
  parameter int MAX_CLASSES = gcpa_pkg::MAX_CLASSES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gcpa_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gcpa_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gcpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  // configuration registers
  logic [gcpa_pkg::CLS_W-1:0]         class_count;
  logic [gcpa_pkg::SD_W-1:0]          noise_sd;
  logic signed [gcpa_pkg::DENS_W-1:0] levels [MAX_CLASSES];
  logic [31:0]                        sd2;
  logic [gcpa_pkg::SD_W-1:0]          sd_eff;

  // whole pipeline advances unless a held result is blocked
  logic en;

  logic                       job_valid;
  logic [31:0]                d2;
  gcpa_pkg::job_t             job;

  logic                       arg_valid;
  logic [gcpa_pkg::ARG_W-1:0] arg;
  logic [$bits(gcpa_pkg::job_t)-1:0] arg_side;

  logic                       e_valid;
  logic [gcpa_pkg::E_W-1:0]   e;
  gcpa_pkg::job_t             e_job;
  gcpa_pkg::tag_t             e_tag;

  logic                        p_valid;
  logic [gcpa_pkg::PROB_W-1:0] p;
  logic [$bits(gcpa_pkg::tag_t)-1:0] p_side;
  gcpa_pkg::tag_t              p_tag;

  // running best of the pixel
  logic [gcpa_pkg::PROB_W-1:0] best_p;
  logic [gcpa_pkg::CLS_W-1:0]  best_i;
  logic                        take;
  logic [gcpa_pkg::CLS_W-1:0]  best_i_next;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= gcpa_pkg::CLS_W'(2);
      noise_sd    <= gcpa_pkg::SD_W'(256);
      for (int i = 0; i < MAX_CLASSES; i++) levels[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcpa_pkg::REG_CLASS_COUNT: class_count <= cfg_data[gcpa_pkg::CLS_W-1:0];
        gcpa_pkg::REG_NOISE_SD:    noise_sd    <= cfg_data;
        default: begin
          // level registers beyond the class limit are dropped
          for (int i = 0; i < MAX_CLASSES; i++) begin
            if (cfg_index == gcpa_pkg::CFG_IDX_W'(int'(gcpa_pkg::REG_LEVEL_0) + i))
              levels[i] <= cfg_data;
          end
        end
      endcase
    end
  end

  // sd of zero acts as one step
  assign sd_eff = (noise_sd == '0) ? gcpa_pkg::SD_W'(1) : noise_sd;

  always_ff @(posedge clk) begin
    sd2 <= 32'(sd_eff) * 32'(sd_eff);
  end

  gcpa_issue #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_issue (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .class_count (class_count),
    .levels      (levels),
    .job_valid   (job_valid),
    .d2          (d2),
    .job         (job)
  );

  // a = d2 * 2^31 / sd^2, argument of the gaussian in Q.16
  gcpa_div #(
    .NW (63),
    .DW (32),
    .QW (gcpa_pkg::ARG_W),
    .SW ($bits(gcpa_pkg::job_t))
  ) u_arg_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (job_valid),
    .num       ({d2, 31'd0}),
    .den       (sd2),
    .side      (job),
    .out_valid (arg_valid),
    .quo       (arg),
    .out_side  (arg_side)
  );

  gcpa_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (arg_valid),
    .arg       (arg),
    .in_job    (gcpa_pkg::job_t'(arg_side)),
    .out_valid (e_valid),
    .e         (e),
    .out_job   (e_job)
  );

  assign e_tag.idx  = e_job.idx;
  assign e_tag.last = e_job.last;

  // probability = e / sum, zero sum saturates through the overflow check
  gcpa_div #(
    .NW (gcpa_pkg::E_W),
    .DW (gcpa_pkg::SUM_W),
    .QW (gcpa_pkg::PROB_W),
    .SW ($bits(gcpa_pkg::tag_t))
  ) u_prob_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .num       (e),
    .den       (e_job.sum),
    .side      (e_tag),
    .out_valid (p_valid),
    .quo       (p),
    .out_side  (p_side)
  );

  assign p_tag = gcpa_pkg::tag_t'(p_side);

  // class 0 opens the pixel; only a strictly larger value takes over
  always_comb begin
    take        = (p_tag.idx == '0) || (p > best_p);
    best_i_next = take ? p_tag.idx : best_i;
  end

  always_ff @(posedge clk) begin
    if (en && p_valid && take) begin
      best_p <= p;
      best_i <= p_tag.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.class_index    <= p_tag.idx;
      out_data.probability    <= p;
      out_data.is_last        <= p_tag.last;
      out_data.restored_level <= p_tag.last ? levels[best_i_next[IW-1:0]] : '0;
    end
  end

  a_level_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_last |-> out_data.restored_level == '0)
    else $error("restored level set on a non-final result");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.class_index < gcpa_pkg::CLS_W'(MAX_CLASSES))
    else $error("class index beyond class limit");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ tb/tb_gaussian_class_probability_assign.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_class_probability_assign
// self-checking bench: pixels go in, every class probability beat is
// predicted in fixed point and compared in order; config is rewritten
// between phases while the block is drained
// ----------------------------------------------------------------------------
module tb_gaussian_class_probability_assign;

  // block latency from pixel beat to first result, plus margin
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_MAX = 20000;

  // expected class beats, oldest first, plus shadow copy of the registers
  class class_prob_board;
    gcpa_pkg::out_item_t pending[$];
    logic [2:0]  cnt_reg;
    logic [15:0] sd_reg;
    logic [15:0] lvl_reg[6];
    int          errors;

    function void clear_regs();
      cnt_reg = 3'd2;
      sd_reg  = 16'd256;
      foreach (lvl_reg[i]) lvl_reg[i] = 16'd0;
      errors  = 0;
    endfunction

    function void write_reg(gcpa_pkg::cfg_reg_t idx, logic [15:0] val);
      case (idx)
        gcpa_pkg::REG_CLASS_COUNT: cnt_reg = val[2:0];
        gcpa_pkg::REG_NOISE_SD:    sd_reg  = val;
        default:                   lvl_reg[int'(idx) - 2] = val;
      endcase
    endfunction

    // exp(-d2/(2 sd^2)) in q1.32
    function logic [63:0] gauss_weight(logic [63:0] d2);
      logic [63:0] sdr, a, t, f, m, n;
      sdr = (sd_reg == 0) ? 64'd1 : 64'(sd_reg);
      a = (d2 << 31) / (sdr * sdr);
      if (a > (64'd40 << 16)) a = 64'd40 << 16;
      t = (a * 64'd94548) >> 16;
      n = t >> 16;
      f = t & 64'hFFFF;
      m = (64'd1 << 32) - 64'd43060 * f + ((64'd10292 * f * f) >> 16);
      if (n > 63) return 64'd0;
      return m >> n;
    endfunction

    function void note_pixel(gcpa_pkg::in_item_t px);
      int cnt, best_i;
      logic [63:0] p, best_p, e, ad;
      longint diff;
      gcpa_pkg::out_item_t r;
      cnt = cnt_reg;
      if (cnt < 1) cnt = 1;
      if (cnt > 6) cnt = 6;
      best_p = 0;
      best_i = 0;
      for (int i = 0; i < cnt; i++) begin
        diff = longint'($signed(lvl_reg[i])) - longint'(px.density);
        ad = (diff < 0) ? 64'(-diff) : 64'(diff);
        e = gauss_weight(ad * ad);
        if (px.prob_sum == 0) p = 65535;
        else begin
          p = e / 64'(px.prob_sum);
          if (p > 65535) p = 65535;
        end
        if (p > best_p) begin
          best_p = p;
          best_i = i;
        end
        r.class_index = 3'(i);
        r.probability = p[15:0];
        r.restored_level = 16'd0;
        r.is_last = 1'b0;
        if (i == cnt - 1) begin
          r.restored_level = lvl_reg[best_i];
          r.is_last = 1'b1;
        end
        pending.push_back(r);
      end
    endfunction

    function void check_beat(gcpa_pkg::out_item_t got);
      gcpa_pkg::out_item_t w;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.class_index !== w.class_index) begin
        $error("class_index exp %0d got %0d", w.class_index, got.class_index);
        errors++;
      end
      if (got.probability !== w.probability) begin
        $error("probability exp %0d got %0d", w.probability, got.probability);
        errors++;
      end
      if (got.restored_level !== w.restored_level) begin
        $error("restored_level exp %0d got %0d", w.restored_level, got.restored_level);
        errors++;
      end
      if (got.is_last !== w.is_last) begin
        $error("is_last exp %0d got %0d", w.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gcpa_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gcpa_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gcpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gcpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  class_prob_board board;
  int idle_cycles = 0;
  bit long_hold = 1'b0;   // receiver hold-off request

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gaussian_class_probability_assign dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: check on accepted beats, stall on its own
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_beat(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stall_proc
    int g;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold && !held) begin
        // long hold so the pipeline fills and pushes back on the input
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        held = 1'b1;
        out_stall <= 1'b0;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_stall <= 1'b1;
        repeat (g + 1) @(negedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("gaussian_class_probability_assign test failed");
      $finish;
    end
  end

  task automatic write_cfg(gcpa_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel beat, with an optional random gap first
  task automatic send_pixel(logic signed [15:0] dens, logic [18:0] sum, bit gaps);
    gcpa_pkg::in_item_t px;
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    px.density = dens;
    px.prob_sum = sum;
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random pixel: densities near a level most of the time, so the
  // probabilities are not all zero
  task automatic random_pixel();
    logic signed [15:0] d;
    logic [18:0] s;
    int k;
    k = $urandom_range(0, 5);
    if ($urandom_range(0, 3) != 0)
      d = $signed(board.lvl_reg[k]) + $signed(16'($urandom_range(0, 64) - 32));
    else
      d = 16'($urandom);
    case ($urandom_range(0, 5))
      0: s = 19'd0;
      1: s = 19'h7FFFF;
      2: s = 19'($urandom_range(1, 8));
      default: s = 19'($urandom_range(1 << 14, 1 << 18));
    endcase
    send_pixel(d, s, 1'b1);
  endtask

  task automatic random_config(int cnt, logic [15:0] sd);
    write_cfg(gcpa_pkg::REG_CLASS_COUNT, 16'(cnt));
    write_cfg(gcpa_pkg::REG_NOISE_SD, sd);
    for (int i = 0; i < 6; i++)
      write_cfg(gcpa_pkg::cfg_reg_t'(gcpa_pkg::REG_LEVEL_0 + i), 16'($urandom));
  endtask

  initial begin
    board = new();
    board.clear_regs();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset registers, field extremes, zero sum, saturation
    send_pixel(16'sd0, 19'd0, 1'b0);
    send_pixel(16'sd0, 19'd1, 1'b0);
    send_pixel(16'sd0, 19'h7FFFF, 1'b0);
    send_pixel(-16'sd32768, 19'd65536, 1'b0);
    send_pixel(16'sd32767, 19'd65536, 1'b0);
    send_pixel(16'sd1, 19'd65536, 1'b0);
    drain();
    write_cfg(gcpa_pkg::REG_CLASS_COUNT, 16'd6);
    write_cfg(gcpa_pkg::REG_NOISE_SD, 16'd65535);
    write_cfg(gcpa_pkg::REG_LEVEL_0, 16'h8000);
    write_cfg(gcpa_pkg::REG_LEVEL_1, 16'h7FFF);
    write_cfg(gcpa_pkg::REG_LEVEL_2, 16'd100);
    write_cfg(gcpa_pkg::REG_LEVEL_3, 16'd100);   // tie with class 2, first wins
    write_cfg(gcpa_pkg::REG_LEVEL_4, 16'hFFFF);
    write_cfg(gcpa_pkg::REG_LEVEL_5, 16'h5555);
    send_pixel(16'sd100, 19'd65536, 1'b0);
    send_pixel(-16'sd32768, 19'd300000, 1'b0);
    send_pixel(16'sd32767, 19'h2AAAA, 1'b0);
    send_pixel(16'sh5555, 19'd0, 1'b0);
    drain();
    // zero class count and zero sd, both mapped to their minimum
    write_cfg(gcpa_pkg::REG_CLASS_COUNT, 16'd0);
    write_cfg(gcpa_pkg::REG_NOISE_SD, 16'd0);
    send_pixel(-16'sd32768, 19'd65536, 1'b0);
    send_pixel(-16'sd32767, 19'd65536, 1'b0);
    drain();
    // count above six clamps; small sd makes all weights vanish
    write_cfg(gcpa_pkg::REG_CLASS_COUNT, 16'd7);
    write_cfg(gcpa_pkg::REG_NOISE_SD, 16'd1);
    send_pixel(16'sd0, 19'd65536, 1'b0);
    send_pixel(16'sd12345, 19'd7, 1'b0);
    drain();

    // random phases with different settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: random_config(1, 16'd256);
        1: random_config(6, 16'd65535);
        2: random_config(6, 16'd1);
        default: random_config($urandom_range(0, 7), 16'($urandom_range(1, 65535)));
      endcase
      if (ph == 3) long_hold = 1'b1;
      for (int n = 0; n < 32; n++) begin
        random_pixel();
        // sender pause until everything is back
        if (ph == 5 && n == 15) begin
          in_valid <= 1'b0;
          while (board.pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("gaussian_class_probability_assign test passed");
    end else begin
      $display("gaussian_class_probability_assign test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gcpa_pkg.sv
rtl/gcpa_div.sv
rtl/gcpa_exp.sv
rtl/gcpa_issue.sv
rtl/gaussian_class_probability_assign.sv
tb/tb_gaussian_class_probability_assign.sv
